// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define SRS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("%m: check failed");

// Clocked assertion that also holds during reset.
`define SRS_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("%m: check failed");

`endif

// ===== sv/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// srs_pkg
// Types and constants of the superpixel region statistics block.
// ----------------------------------------------------------------------------
package srs_pkg;

   localparam int LABELS      = 256;
   localparam int LABEL_BITS  = $clog2(LABELS);
   localparam int CHANNELS    = 3;
   localparam int IN_CHANNELS = 3;
   localparam int PIXEL_BITS  = 8;
   localparam int NVALS       = 1 << PIXEL_BITS;
   localparam int WEIGHT_BITS = 16;
   localparam int COUNT_BITS  = 20;
   localparam int TOT_BITS    = WEIGHT_BITS + COUNT_BITS;
   localparam int SUM_BITS    = PIXEL_BITS + TOT_BITS;
   localparam int PROD_BITS   = PIXEL_BITS + WEIGHT_BITS;
   localparam int BIN_BITS    = TOT_BITS + 1;
   localparam int BIN_DEPTH   = LABELS * NVALS;
   localparam int BIN_ADDR    = $clog2(BIN_DEPTH);
   localparam int CUM_BITS    = SUM_BITS;
   localparam int QUO_BITS    = PIXEL_BITS + 1;
   localparam int STEP_BITS   = $clog2(QUO_BITS + 1);
   localparam int RES_BITS    = 8;
   localparam int MODE_BITS   = 2;

   localparam logic [MODE_BITS-1:0] MODE_MEAN   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_MEDIAN = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_MAXW   = 2'd2;

   typedef enum logic [1:0] {
      FUNC_ACC = 2'd0,
      FUNC_FIN = 2'd1,
      FUNC_QRY = 2'd2,
      FUNC_CLR = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_FIN_LOAD,
      ST_FIN_TOT,
      ST_FIN_DIV,
      ST_FIN_SCAN,
      ST_FIN_DRAIN,
      ST_FIN_WRITE,
      ST_QRY_RD,
      ST_QRY_OUT
   } state_type;

   typedef struct packed {
      logic [LABEL_BITS-1:0]  label;
      logic [PIXEL_BITS-1:0]  sub;
      logic                   use_sub;
      logic                   clear;
      logic                   sum_we;
      logic                   bin_we;
      logic                   prod_en;
      logic                   fin_init;
      logic                   div_step;
      logic                   proc;
      logic [PIXEL_BITS-1:0]  proc_v;
      logic                   res_we;
      logic [MODE_BITS-1:0]   mode;
      logic [TOT_BITS-1:0]    tot;
      logic [WEIGHT_BITS-1:0] weight;
   } lane_ctl_type;

   typedef struct packed {
      func_type               func;
      logic [LABEL_BITS-1:0]  label;
      logic [PIXEL_BITS-1:0]  pix0;
      logic [PIXEL_BITS-1:0]  pix1;
      logic [PIXEL_BITS-1:0]  pix2;
      logic [WEIGHT_BITS-1:0] weight;
   } item_type;

endpackage

// ===== sv/srs_if.sv =====
// ----------------------------------------------------------------------------
// srs_req_if / srs_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface srs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] label;
   logic [7:0] pixel_value_0;
   logic [7:0] pixel_value_1;
   logic [7:0] pixel_value_2;
   logic [15:0] pixel_weight;

   modport source (output valid, func, label, pixel_value_0, pixel_value_1,
                   pixel_value_2, pixel_weight, input ready);
   modport sink (input valid, func, label, pixel_value_0, pixel_value_1,
                 pixel_value_2, pixel_weight, output ready);
endinterface

interface srs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] query_label;
   logic [7:0] result_0;
   logic [7:0] result_1;
   logic [7:0] result_2;

   modport source (output valid, query_label, result_0, result_1, result_2,
                   input ready);
   modport sink (input valid, query_label, result_0, result_1, result_2,
                 output ready);
endinterface

// ===== sv/superpixel_region_statistics_top.sv =====
// ----------------------------------------------------------------------------
// superpixel_region_statistics_top
// Per-label weighted mean, median or max-weight value over three channels.
//
//  channel  direction  handshake     word
//  req      in         valid/ready   func, label, three samples, weight
//  rsp      out        valid/ready   query label, three results
//  csr      in         write enable  mode
//
// After reset, and after each clear word, a sweep over every bin address empties
// all but the result store; no word is taken meanwhile. Accumulate does a bin
// memory read-modify-write, query a result read that waits out a response stall.
// Finish walks all 256 labels, per label running the divider in mean mode,
// a bin scan in median and max-weight mode, and only the result write otherwise.
// A response waits in its output register while the next word is taken.
// ----------------------------------------------------------------------------
module superpixel_region_statistics_top (
   input  logic              clock,
   input  logic              reset,
   srs_req_if.sink           req,
   srs_rsp_if.source         rsp,
   input  logic              csr_we,
   input  logic [1:0]        csr_wdata
);

   logic [srs_pkg::MODE_BITS-1:0] mode_ff;
   srs_pkg::item_type             item_ff;
   srs_pkg::lane_ctl_type         ctl;
   logic                          start, ready, rsp_load, rsp_free;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [srs_pkg::RES_BITS-1:0]  res_ff [3];
   logic [srs_pkg::LABEL_BITS-1:0] rlabel_ff;
   logic [srs_pkg::RES_BITS-1:0]  lane_q [srs_pkg::CHANNELS];
   logic [srs_pkg::PIXEL_BITS-1:0] pix [srs_pkg::IN_CHANNELS];

   assign start     = req.valid && ready;
   assign req.ready = ready;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= srs_pkg::MODE_MEAN;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
      if (start) begin
         item_ff.func   <= srs_pkg::func_type'(req.func);
         item_ff.label  <= req.label;
         item_ff.pix0   <= req.pixel_value_0;
         item_ff.pix1   <= req.pixel_value_1;
         item_ff.pix2   <= req.pixel_value_2;
         item_ff.weight <= req.pixel_weight;
      end
   end

   assign pix[0] = item_ff.pix0;
   assign pix[1] = item_ff.pix1;
   assign pix[2] = item_ff.pix2;

   srs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .mode(mode_ff), .start(start),
      .func(srs_pkg::func_type'(req.func)), .label(req.label),
      .weight(item_ff.weight), .rsp_free(rsp_free), .ready(ready),
      .rsp_load(rsp_load), .ctl(ctl)
   );

   for (genvar g = 0; g < srs_pkg::CHANNELS; g++) begin : g_lane
      logic [srs_pkg::PIXEL_BITS-1:0] lane_val;
      if (g < srs_pkg::IN_CHANNELS) begin : g_in
         assign lane_val = pix[g];
      end else begin : g_zero
         assign lane_val = '0;
      end
      srs_lane u_lane (
         .clock(clock), .reset(reset), .ctl(ctl), .value(lane_val),
         .qry_data(lane_q[g])
      );
   end

   // Merge: gather the lanes' answers into the response register.
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rlabel_ff <= item_ff.label;
         for (int k = 0; k < 3; k++) begin
            res_ff[k] <= (k < srs_pkg::CHANNELS) ? lane_q[k] : '0;
         end
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.query_label = rlabel_ff;
   assign rsp.result_0    = res_ff[0];
   assign rsp.result_1    = res_ff[1];
   assign rsp.result_2    = res_ff[2];

endmodule

// ===== sv/srs_ram.sv =====
// ----------------------------------------------------------------------------
// srs_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module srs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/srs_lane.sv =====
// ----------------------------------------------------------------------------
// srs_lane
// One channel: sum and histogram stores, divider, scan unit and results.
// ----------------------------------------------------------------------------
module srs_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  srs_pkg::lane_ctl_type         ctl,
   input  logic [srs_pkg::PIXEL_BITS-1:0] value,
   output logic [srs_pkg::RES_BITS-1:0]   qry_data
);

   logic [srs_pkg::SUM_BITS-1:0]   sum_rd, sum_wd;
   logic [srs_pkg::BIN_BITS-1:0]   bin_rd, bin_wd;
   logic [srs_pkg::BIN_ADDR-1:0]   bin_addr;
   logic [srs_pkg::RES_BITS-1:0]   stat;
   logic [srs_pkg::SUM_BITS:0]     sum_add;
   logic [srs_pkg::TOT_BITS:0]     bin_add;
   logic [srs_pkg::TOT_BITS-1:0]   bin_w;
   logic                           bin_p;

   logic [srs_pkg::PROD_BITS-1:0]  prod_ff, prod_in;
   logic [srs_pkg::SUM_BITS:0]     rem_ff, rem_in;
   logic [srs_pkg::SUM_BITS-1:0]   d_ff, d_in;
   logic [srs_pkg::QUO_BITS-1:0]   q_ff, q_in;
   logic [srs_pkg::CUM_BITS-1:0]   cum_ff, cum_in, cum_next;
   logic                           found_ff, found_in;
   logic [srs_pkg::PIXEL_BITS-1:0] med_ff, med_in, last_ff, last_in;
   logic                           mfound_ff, mfound_in;
   logic [srs_pkg::TOT_BITS-1:0]   best_w_ff, best_w_in;
   logic [srs_pkg::PIXEL_BITS-1:0] best_v_ff, best_v_in;
   logic                           ge, hit;

   assign bin_addr = {ctl.label, (ctl.use_sub ? ctl.sub : value)};
   assign bin_p    = bin_rd[srs_pkg::TOT_BITS];
   assign bin_w    = bin_rd[srs_pkg::TOT_BITS-1:0];

   // Saturating updates for an accumulated pixel.
   assign sum_add = {1'b0, sum_rd}
                  + {{(srs_pkg::SUM_BITS + 1 - srs_pkg::PROD_BITS){1'b0}}, prod_ff};
   assign bin_add = {1'b0, bin_w}
                  + {{(srs_pkg::TOT_BITS + 1 - srs_pkg::WEIGHT_BITS){1'b0}}, ctl.weight};

   always_comb begin
      if (ctl.clear) begin
         sum_wd = '0;
         bin_wd = '0;
      end else begin
         sum_wd = sum_add[srs_pkg::SUM_BITS] ? '1 : sum_add[srs_pkg::SUM_BITS-1:0];
         bin_wd = {1'b1, (bin_add[srs_pkg::TOT_BITS] ? {srs_pkg::TOT_BITS{1'b1}}
                                                     : bin_add[srs_pkg::TOT_BITS-1:0])};
      end
   end

   srs_ram #(.WIDTH(srs_pkg::SUM_BITS), .DEPTH(srs_pkg::LABELS)) u_sum (
      .clock(clock), .we(ctl.sum_we), .addr(ctl.label), .wdata(sum_wd), .rdata(sum_rd)
   );

   srs_ram #(.WIDTH(srs_pkg::BIN_BITS), .DEPTH(srs_pkg::BIN_DEPTH)) u_bin (
      .clock(clock), .we(ctl.bin_we), .addr(bin_addr), .wdata(bin_wd), .rdata(bin_rd)
   );

   srs_ram #(.WIDTH(srs_pkg::RES_BITS), .DEPTH(srs_pkg::LABELS)) u_res (
      .clock(clock), .we(ctl.res_we), .addr(ctl.label), .wdata(stat), .rdata(qry_data)
   );

   assign ge       = rem_ff >= {1'b0, d_ff};
   assign cum_next = cum_ff + {{(srs_pkg::CUM_BITS - srs_pkg::TOT_BITS){1'b0}}, bin_w};
   assign hit      = {cum_next, 1'b0} >= {{(srs_pkg::CUM_BITS + 1 - srs_pkg::TOT_BITS){1'b0}},
                                          ctl.tot};

   always_comb begin
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      d_in      = d_ff;
      q_in      = q_ff;
      cum_in    = cum_ff;
      found_in  = found_ff;
      med_in    = med_ff;
      last_in   = last_ff;
      mfound_in = mfound_ff;
      best_w_in = best_w_ff;
      best_v_in = best_v_ff;
      if (ctl.prod_en) begin
         prod_in = value * ctl.weight;
      end
      if (ctl.fin_init) begin
         rem_in    = {1'b0, sum_rd};
         d_in      = {ctl.tot, {srs_pkg::PIXEL_BITS{1'b0}}};
         q_in      = '0;
         cum_in    = '0;
         found_in  = 1'b0;
         last_in   = '0;
         mfound_in = 1'b0;
      end
      // Restoring division, one quotient bit a cycle.
      if (ctl.div_step) begin
         if (ge) begin
            rem_in = rem_ff - {1'b0, d_ff};
         end
         q_in = {q_ff[srs_pkg::QUO_BITS-2:0], ge};
         d_in = d_ff >> 1;
      end
      if (ctl.proc && bin_p) begin
         last_in = ctl.proc_v;
         if (!found_ff) begin
            if (hit) begin
               found_in = 1'b1;
               med_in   = ctl.proc_v;
            end else begin
               cum_in = cum_next;
            end
         end
         if (!mfound_ff || (best_w_ff < bin_w)) begin
            mfound_in = 1'b1;
            best_w_in = bin_w;
            best_v_in = ctl.proc_v;
         end
      end
   end

   always_comb begin
      case (ctl.mode)
         srs_pkg::MODE_MEAN: begin
            stat = (ctl.tot == '0) ? '0 : q_ff[srs_pkg::RES_BITS-1:0];
         end
         srs_pkg::MODE_MEDIAN: begin
            stat = (ctl.tot == '0) ? '0 : (found_ff ? med_ff : last_ff);
         end
         srs_pkg::MODE_MAXW: begin
            stat = mfound_ff ? best_v_ff : '0;
         end
         default: begin
            stat = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff  <= 1'b0;
         mfound_ff <= 1'b0;
      end else begin
         found_ff  <= found_in;
         mfound_ff <= mfound_in;
      end
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      d_ff      <= d_in;
      q_ff      <= q_in;
      cum_ff    <= cum_in;
      med_ff    <= med_in;
      last_ff   <= last_in;
      best_w_ff <= best_w_in;
      best_v_ff <= best_v_in;
   end

endmodule

// ===== sv/srs_ctrl.sv =====
// ----------------------------------------------------------------------------
// srs_ctrl
// Sequencer: clearing sweep, accumulate, finish pass and query; weight totals.
// ----------------------------------------------------------------------------
module srs_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [srs_pkg::MODE_BITS-1:0]   mode,
   input  logic                            start,
   input  srs_pkg::func_type               func,
   input  logic [srs_pkg::LABEL_BITS-1:0]  label,
   input  logic [srs_pkg::WEIGHT_BITS-1:0] weight,
   input  logic                            rsp_free,
   output logic                            ready,
   output logic                            rsp_load,
   output srs_pkg::lane_ctl_type           ctl
);

   srs_pkg::state_type state_ff, state_in;
   logic [srs_pkg::LABEL_BITS-1:0] lbl_ff, lbl_in;
   logic [srs_pkg::BIN_ADDR-1:0]   clr_ff, clr_in;
   logic [srs_pkg::STEP_BITS-1:0]  step_ff, step_in;
   logic [srs_pkg::PIXEL_BITS-1:0] vcnt_ff, vcnt_in, pv_ff, pv_in;
   logic                           pvld_ff, pvld_in;
   logic [srs_pkg::TOT_BITS-1:0]   tot_ff, tot_in, tot_rd, tot_wd;
   logic [srs_pkg::TOT_BITS:0]     tot_add;
   logic                           tot_we;
   logic [srs_pkg::LABEL_BITS-1:0] addr_lbl;
   logic                           clearing;

   assign clearing = state_ff == srs_pkg::ST_CLEAR;
   assign addr_lbl = clearing ? clr_ff[srs_pkg::BIN_ADDR-1:srs_pkg::PIXEL_BITS] : lbl_ff;
   assign tot_add  = {1'b0, tot_rd}
                   + {{(srs_pkg::TOT_BITS + 1 - srs_pkg::WEIGHT_BITS){1'b0}}, weight};
   assign tot_wd   = clearing ? '0
                   : (tot_add[srs_pkg::TOT_BITS] ? '1 : tot_add[srs_pkg::TOT_BITS-1:0]);
   assign tot_we   = clearing || (state_ff == srs_pkg::ST_ACC_WR);

   srs_ram #(.WIDTH(srs_pkg::TOT_BITS), .DEPTH(srs_pkg::LABELS)) u_tot (
      .clock(clock), .we(tot_we), .addr(addr_lbl), .wdata(tot_wd), .rdata(tot_rd)
   );

   always_comb begin
      state_in = state_ff;
      lbl_in   = lbl_ff;
      clr_in   = clr_ff;
      step_in  = step_ff;
      vcnt_in  = vcnt_ff;
      pvld_in  = 1'b0;
      pv_in    = pv_ff;
      tot_in   = tot_ff;
      ready    = 1'b0;
      rsp_load = 1'b0;

      ctl          = '0;
      ctl.label    = addr_lbl;
      ctl.sub      = clearing ? clr_ff[srs_pkg::PIXEL_BITS-1:0] : vcnt_ff;
      ctl.use_sub  = clearing || (state_ff == srs_pkg::ST_FIN_SCAN);
      ctl.clear    = clearing;
      ctl.proc     = pvld_ff;
      ctl.proc_v   = pv_ff;
      ctl.mode     = mode;
      ctl.tot      = (state_ff == srs_pkg::ST_FIN_TOT) ? tot_rd : tot_ff;
      ctl.weight   = weight;

      case (state_ff)
         srs_pkg::ST_CLEAR: begin
            ctl.sum_we = 1'b1;
            ctl.bin_we = 1'b1;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = srs_pkg::ST_IDLE;
            end
         end
         srs_pkg::ST_IDLE: begin
            ready = 1'b1;
            if (start) begin
               lbl_in = label;
               case (func)
                  srs_pkg::FUNC_ACC: begin
                     state_in = srs_pkg::ST_ACC_RD;
                  end
                  srs_pkg::FUNC_FIN: begin
                     lbl_in   = '0;
                     state_in = srs_pkg::ST_FIN_LOAD;
                  end
                  srs_pkg::FUNC_QRY: begin
                     state_in = srs_pkg::ST_QRY_RD;
                  end
                  default: begin
                     clr_in   = '0;
                     state_in = srs_pkg::ST_CLEAR;
                  end
               endcase
            end
         end
         srs_pkg::ST_ACC_RD: begin
            ctl.prod_en = 1'b1;
            state_in    = srs_pkg::ST_ACC_WR;
         end
         srs_pkg::ST_ACC_WR: begin
            ctl.sum_we = 1'b1;
            ctl.bin_we = 1'b1;
            state_in   = srs_pkg::ST_IDLE;
         end
         srs_pkg::ST_FIN_LOAD: begin
            state_in = srs_pkg::ST_FIN_TOT;
         end
         srs_pkg::ST_FIN_TOT: begin
            ctl.fin_init = 1'b1;
            tot_in       = tot_rd;
            step_in      = '0;
            vcnt_in      = '0;
            case (mode)
               srs_pkg::MODE_MEAN: begin
                  state_in = srs_pkg::ST_FIN_DIV;
               end
               srs_pkg::MODE_MEDIAN, srs_pkg::MODE_MAXW: begin
                  state_in = srs_pkg::ST_FIN_SCAN;
               end
               default: begin
                  state_in = srs_pkg::ST_FIN_WRITE;
               end
            endcase
         end
         srs_pkg::ST_FIN_DIV: begin
            ctl.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == srs_pkg::STEP_BITS'(srs_pkg::QUO_BITS - 1)) begin
               state_in = srs_pkg::ST_FIN_WRITE;
            end
         end
         srs_pkg::ST_FIN_SCAN: begin
            // Bin data comes back in the next cycle and is processed then.
            pvld_in = 1'b1;
            pv_in   = vcnt_ff;
            vcnt_in = vcnt_ff + 1'b1;
            if (vcnt_ff == '1) begin
               state_in = srs_pkg::ST_FIN_DRAIN;
            end
         end
         srs_pkg::ST_FIN_DRAIN: begin
            state_in = srs_pkg::ST_FIN_WRITE;
         end
         srs_pkg::ST_FIN_WRITE: begin
            ctl.res_we = 1'b1;
            lbl_in     = lbl_ff + 1'b1;
            state_in   = (lbl_ff == '1) ? srs_pkg::ST_IDLE : srs_pkg::ST_FIN_LOAD;
         end
         srs_pkg::ST_QRY_RD: begin
            state_in = srs_pkg::ST_QRY_OUT;
         end
         srs_pkg::ST_QRY_OUT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = srs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srs_pkg::ST_CLEAR;
         clr_ff   <= '0;
         pvld_ff  <= 1'b0;
         step_ff  <= '0;
         vcnt_ff  <= '0;
         lbl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pvld_ff  <= pvld_in;
         step_ff  <= step_in;
         vcnt_ff  <= vcnt_in;
         lbl_ff   <= lbl_in;
      end
      pv_ff  <= pv_in;
      tot_ff <= tot_in;
   end

endmodule

// ===== sv/srs_checker.sv =====
// ----------------------------------------------------------------------------
// srs_checker
// Port-level checks of the region statistics block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_query_label,
   input logic [7:0] rsp_result_0
);

   // The clearing sweep follows reset, so no word is taken right after it.
   `SRS_ASSERT(a_clear_after_reset, $past(reset) |-> !req_ready)
   // Every accepted word makes the block busy, so ready drops after it.
   `SRS_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready)
   // A stalled response stays and holds its word.
   `SRS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_query_label))
   `SRS_ASSERT(a_rsp_data_hold, rsp_valid && !rsp_ready |=> $stable(rsp_result_0))
   `SRS_ASSERT_ALWAYS(a_rsp_reset, reset |=> !rsp_valid)

endmodule

bind superpixel_region_statistics_top srs_checker u_srs_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_query_label(rsp.query_label), .rsp_result_0(rsp.result_0)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives request words into the region statistics block, keeps its own model
// of the per-label store and finish pass, and checks every query response
// field by field. Runs phases in all modes, with random stalls on both sides or none.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int SETTLE_CYCLES  = 40;
   localparam longint unsigned TOT_SAT = (64'd1 << srs_pkg::TOT_BITS) - 1;
   localparam longint unsigned SUM_SAT = (64'd1 << srs_pkg::SUM_BITS) - 1;

   typedef struct {
      logic [7:0] query_label;
      logic [7:0] res0;
      logic [7:0] res1;
      logic [7:0] res2;
   } answer_type;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_wdata;

   srs_req_if req_ch ();
   srs_rsp_if rsp_ch ();

   superpixel_region_statistics_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Model of the block's store.
   longint unsigned  sum_mem [srs_pkg::LABELS*srs_pkg::CHANNELS];
   longint unsigned  tot_mem [srs_pkg::LABELS];
   longint unsigned  bin_mem [srs_pkg::LABELS*srs_pkg::CHANNELS*srs_pkg::NVALS];
   bit               pres_mem [srs_pkg::LABELS*srs_pkg::CHANNELS*srs_pkg::NVALS];
   logic [7:0]       stat_mem [srs_pkg::LABELS*srs_pkg::CHANNELS];
   logic [1:0]       mode_q;

   srs_pkg::item_type pending_words[$];
   answer_type        expected_answers[$];
   int                send_idle_pct;
   int                recv_idle_pct;
   int                err_count;
   int                quiet_cycles;
   bit                finish_issued;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                                longint unsigned lim);
      longint unsigned s;
      s = a + b;
      return (s > lim) ? lim : s;
   endfunction

   function automatic void clear_model();
      foreach (sum_mem[i]) sum_mem[i] = 0;
      foreach (tot_mem[i]) tot_mem[i] = 0;
      foreach (bin_mem[i]) begin
         bin_mem[i] = 0;
         pres_mem[i] = 1'b0;
      end
   endfunction

   function automatic logic [7:0] region_stat(int lab, int c);
      longint unsigned t;
      longint unsigned cum;
      int base;
      int last;
      int best;
      bit found;
      t = tot_mem[lab];
      base = (lab*srs_pkg::CHANNELS + c) * srs_pkg::NVALS;
      cum = 0;
      last = 0;
      best = 0;
      found = 1'b0;
      case (mode_q)
         srs_pkg::MODE_MEAN: begin
            if (t == 0) return 8'd0;
            return 8'(sum_mem[lab*srs_pkg::CHANNELS + c] / t);
         end
         srs_pkg::MODE_MEDIAN: begin
            if (t == 0) return 8'd0;
            for (int v = 0; v < srs_pkg::NVALS; v++) begin
               if (pres_mem[base+v]) begin
                  last = v;
                  if (2*(cum + bin_mem[base+v]) >= t) return 8'(v);
                  cum += bin_mem[base+v];
               end
            end
            return 8'(last);
         end
         srs_pkg::MODE_MAXW: begin
            for (int v = 0; v < srs_pkg::NVALS; v++) begin
               if (pres_mem[base+v] && (!found || bin_mem[base+best] < bin_mem[base+v])) begin
                  best = v;
                  found = 1'b1;
               end
            end
            return 8'(best);
         end
         default: return 8'd0;
      endcase
   endfunction

   // Applies one accepted word to the model and queues the answer of a query.
   function automatic void apply_word(srs_pkg::item_type w);
      logic [7:0] vals[3];
      answer_type a;
      int slot;
      vals[0] = w.pix0;
      vals[1] = w.pix1;
      vals[2] = w.pix2;
      case (w.func)
         srs_pkg::FUNC_ACC: begin
            tot_mem[w.label] = sat_sum(tot_mem[w.label], w.weight, TOT_SAT);
            for (int c = 0; c < srs_pkg::CHANNELS; c++) begin
               slot = w.label*srs_pkg::CHANNELS + c;
               sum_mem[slot] = sat_sum(sum_mem[slot],
                                       64'(vals[c]) * 64'(w.weight), SUM_SAT);
               bin_mem[slot*srs_pkg::NVALS + vals[c]] =
                  sat_sum(bin_mem[slot*srs_pkg::NVALS + vals[c]], w.weight, TOT_SAT);
               pres_mem[slot*srs_pkg::NVALS + vals[c]] = 1'b1;
            end
         end
         srs_pkg::FUNC_FIN: begin
            for (int l = 0; l < srs_pkg::LABELS; l++)
               for (int c = 0; c < srs_pkg::CHANNELS; c++)
                  stat_mem[l*srs_pkg::CHANNELS + c] = region_stat(l, c);
         end
         srs_pkg::FUNC_QRY: begin
            a.query_label = w.label;
            a.res0 = stat_mem[w.label*srs_pkg::CHANNELS];
            a.res1 = stat_mem[w.label*srs_pkg::CHANNELS + 1];
            a.res2 = stat_mem[w.label*srs_pkg::CHANNELS + 2];
            expected_answers.push_back(a);
         end
         default: clear_model();
      endcase
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_word('{srs_pkg::func_type'(req_ch.func), req_ch.label,
                         req_ch.pixel_value_0, req_ch.pixel_value_1,
                         req_ch.pixel_value_2, req_ch.pixel_weight});
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               srs_pkg::item_type w;
               w = pending_words.pop_front();
               req_ch.valid         <= 1'b1;
               req_ch.func          <= w.func;
               req_ch.label         <= w.label;
               req_ch.pixel_value_0 <= w.pix0;
               req_ch.pixel_value_1 <= w.pix1;
               req_ch.pixel_value_2 <= w.pix2;
               req_ch.pixel_weight  <= w.weight;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and receiver stalls.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_answers.size() == 0) begin
            if (err_count < 10)
               $display("unexpected response word: label %0d", rsp_ch.query_label);
            err_count++;
         end else begin
            answer_type e;
            e = expected_answers.pop_front();
            if (e.query_label !== rsp_ch.query_label || e.res0 !== rsp_ch.result_0 ||
                e.res1 !== rsp_ch.result_1 || e.res2 !== rsp_ch.result_2) begin
               if (err_count < 10)
                  $display("mismatch: expected %0d:%0d/%0d/%0d got %0d:%0d/%0d/%0d",
                           e.query_label, e.res0, e.res1, e.res2, rsp_ch.query_label,
                           rsp_ch.result_0, rsp_ch.result_1, rsp_ch.result_2);
               err_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted word.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_word(srs_pkg::func_type f, int lab, int v0, int v1, int v2, int wt);
      srs_pkg::item_type w;
      w.func = f;
      w.label = 8'(lab);
      w.pix0 = 8'(v0);
      w.pix1 = 8'(v1);
      w.pix2 = 8'(v2);
      w.weight = 16'(wt);
      pending_words.push_back(w);
   endtask

   function automatic int rand_sample();
      if ($urandom_range(2) == 0) return $urandom_range(255);
      return $urandom_range(7) * 36;
   endfunction

   function automatic int rand_weight();
      case ($urandom_range(9))
         0: return 0;
         1: return 65535;
         2: return $urandom_range(65535);
         default: return $urandom_range(1, 300);
      endcase
   endfunction

   function automatic int rand_label(int base);
      if ($urandom_range(4) == 0) return $urandom_range(255);
      return (base + $urandom_range(11)) % srs_pkg::LABELS;
   endfunction

   // Waits until every word is sent and answered, then lets the block settle.
   task automatic wait_idle();
      while (pending_words.size() > 0 || req_ch.valid || expected_answers.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(logic [1:0] m);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= m;
      mode_q = m;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(logic [1:0] m, bit with_clear, int n_acc, int n_qry);
      int base;
      write_mode(m);
      base = $urandom_range(255);
      if (with_clear) push_word(srs_pkg::FUNC_CLR, $urandom_range(255), 0, 0, 0, 0);
      for (int i = 0; i < n_acc; i++) begin
         if (finish_issued && $urandom_range(19) == 0)
            push_word(srs_pkg::FUNC_QRY, rand_label(base), rand_sample(), 0, 0,
                      rand_weight());
         else
            push_word(srs_pkg::FUNC_ACC, rand_label(base), rand_sample(), rand_sample(),
                      rand_sample(), rand_weight());
      end
      push_word(srs_pkg::FUNC_FIN, $urandom_range(255), $urandom_range(255), 0, 0, 0);
      finish_issued = 1'b1;
      for (int i = 0; i < n_qry; i++)
         push_word(srs_pkg::FUNC_QRY, rand_label(base), $urandom_range(255),
                   $urandom_range(255), $urandom_range(255), $urandom_range(65535));
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 2'd0;
      req_ch.valid = 1'b0;
      req_ch.func = srs_pkg::FUNC_ACC;
      req_ch.label = 8'd0;
      req_ch.pixel_value_0 = 8'd0;
      req_ch.pixel_value_1 = 8'd0;
      req_ch.pixel_value_2 = 8'd0;
      req_ch.pixel_weight = 16'd0;
      rsp_ch.ready = 1'b0;
      err_count = 0;
      quiet_cycles = 0;
      finish_issued = 1'b0;
      mode_q = srs_pkg::MODE_MEAN;
      send_idle_pct = 17;
      recv_idle_pct = 52;
      clear_model();
      foreach (stat_mem[i]) stat_mem[i] = 8'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed words: field extremes, a zero-weight label, an empty label.
      write_mode(srs_pkg::MODE_MEAN);
      push_word(srs_pkg::FUNC_ACC, 0, 0, 0, 0, 65535);
      push_word(srs_pkg::FUNC_ACC, 0, 255, 255, 255, 1);
      push_word(srs_pkg::FUNC_ACC, 255, 255, 0, 128, 65535);
      push_word(srs_pkg::FUNC_ACC, 255, 1, 254, 127, 0);
      push_word(srs_pkg::FUNC_ACC, 7, 200, 10, 90, 0);
      push_word(srs_pkg::FUNC_ACC, 7, 30, 40, 50, 0);
      push_word(srs_pkg::FUNC_ACC, 9, 85, 170, 15, 43690);
      push_word(srs_pkg::FUNC_FIN, 0, 0, 0, 0, 0);
      finish_issued = 1'b1;
      push_word(srs_pkg::FUNC_QRY, 0, 0, 0, 0, 0);
      push_word(srs_pkg::FUNC_QRY, 255, 255, 255, 255, 65535);
      push_word(srs_pkg::FUNC_QRY, 7, 0, 0, 0, 0);
      push_word(srs_pkg::FUNC_QRY, 100, 0, 0, 0, 0);
      push_word(srs_pkg::FUNC_QRY, 9, 0, 0, 0, 0);
      wait_idle();
      write_mode(srs_pkg::MODE_MAXW);
      push_word(srs_pkg::FUNC_FIN, 0, 0, 0, 0, 0);
      push_word(srs_pkg::FUNC_QRY, 7, 0, 0, 0, 0);
      push_word(srs_pkg::FUNC_QRY, 255, 0, 0, 0, 0);
      push_word(srs_pkg::FUNC_QRY, 100, 0, 0, 0, 0);
      wait_idle();

      run_phase(srs_pkg::MODE_MEDIAN, 1'b0, 280, 40);
      send_idle_pct = 52;
      recv_idle_pct = 17;
      run_phase(srs_pkg::MODE_MAXW, 1'b1, 280, 40);
      run_phase(2'd3, 1'b0, 280, 40);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(srs_pkg::MODE_MAXW, 1'b1, 280, 40);
      run_phase(srs_pkg::MODE_MEAN, 1'b0, 280, 40);

      if (err_count == 0 && expected_answers.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
